@@ rtl/alarm_led_buzzer_pattern_gen_defines.svh @@
// ----------------------------------------------------------------------------
// Alarm LED / buzzer pattern generator: assertion macros
// Shared property forms for the checker that watches the block's ports.
// ----------------------------------------------------------------------------
`ifndef ALARM_LED_BUZZER_PATTERN_GEN_DEFINES_SVH
`define ALARM_LED_BUZZER_PATTERN_GEN_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define ALBPG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define ALBPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/albpg_pkg.sv @@
// ----------------------------------------------------------------------------
// Alarm LED / buzzer pattern generator package
// Request, status and pattern codes, register indexes and the result type.
// ----------------------------------------------------------------------------
package albpg_pkg;

  localparam int unsigned LED_W     = 8;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned PERIOD_W  = 16;
  localparam int unsigned FADE_W    = 10;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LED_LEVEL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_STEP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUZZER_ENABLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_PERIOD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INTER_ON      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INTER_OFF     = 3'd5;

  // Register reset values
  localparam logic [LED_W-1:0]    LED_LEVEL_RST    = 8'd255;
  localparam logic [LED_W-1:0]    FADE_STEP_RST    = 8'd5;
  localparam logic [PERIOD_W-1:0] PULSE_PERIOD_RST = 16'd1000;
  localparam logic [PERIOD_W-1:0] INTER_ON_RST     = 16'd200;
  localparam logic [PERIOD_W-1:0] INTER_OFF_RST    = 16'd800;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_STATUS  = 2'd1,
    REQ_PATTERN = 2'd2,
    REQ_SILENCE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_NORMAL  = 2'd0,
    ST_DANGER  = 2'd1,
    ST_WARNING = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PAT_OFF          = 2'd0,
    PAT_CONTINUOUS   = 2'd1,
    PAT_PULSE        = 2'd2,
    PAT_INTERMITTENT = 2'd3
  } pattern_e;

  typedef struct packed {
    logic [LED_W-1:0] red;
    logic [LED_W-1:0] yellow;
    logic [LED_W-1:0] green;
    logic             buzzer;
    logic             alarm;
    logic [1:0]       status;
  } result_t;

endpackage

@@ rtl/alarm_led_buzzer_pattern_gen.sv @@
// ----------------------------------------------------------------------------
// Alarm LED / buzzer pattern generator
// Drives red/yellow/green LED duties and a buzzer from tick, status-update,
// pattern-set and silence requests; one result per request.
// ----------------------------------------------------------------------------
// Usage: every accepted request returns one result holding the LED duties,
// buzzer level, alarm flag and status as they stand after that request. Its
// whole effect is computed from the port payload and the held state in one
// pass, and at the accept edge the state registers load together with the
// output register, or with the skid register when the output entry is
// stalled. One request can be accepted every cycle while in_ready_o is high; a
// two-entry output buffer (output register plus skid register) keeps the input
// side open for one more request while a result waits, so in_ready_o drops
// only when both entries are full. Configuration writes take effect at the
// edge where cfg_we_i is high and are meant for idle periods; writing 0 to
// buzzer_enable also drives the held buzzer level low if no request is accepted.
// Ticks advance the warning fade and evaluate the buzzer pattern against now_ms.
// ----------------------------------------------------------------------------
module alarm_led_buzzer_pattern_gen (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] now_ms_i,
  input  logic [1:0]  status_code_i,
  input  logic [1:0]  pattern_code_i,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_level_o,
  output logic [7:0]  yellow_level_o,
  output logic [7:0]  green_level_o,
  output logic        buzzer_on_o,
  output logic        alarm_active_o,
  output logic [1:0]  status_now_o
);

  // Configuration registers
  logic [7:0]  led_level_q;
  logic [7:0]  fade_step_q;
  logic        buzzer_en_q;
  logic [15:0] pulse_period_q;
  logic [15:0] inter_on_q;
  logic [15:0] inter_off_q;

  // Block state
  albpg_pkg::status_e  status_q,  status_d;
  albpg_pkg::pattern_e mode_q,    mode_d;
  logic                alarm_q,   alarm_d;
  logic [31:0]         last_q,    last_d;
  logic                phase_q,   phase_d;
  logic [9:0]          fade_q,    fade_d;
  logic                rising_q,  rising_d;
  logic                pin_q,     pin_d;
  logic [7:0]          red_q,     red_d;
  logic [7:0]          yel_q,     yel_d;
  logic [7:0]          grn_q,     grn_d;

  // Output buffer
  logic                out_valid_q;
  logic                skid_valid_q;
  albpg_pkg::result_t  out_q;
  albpg_pkg::result_t  skid_q;
  albpg_pkg::result_t  res;

  logic in_fire;
  logic out_fire;

  // Refresh and buzzer datapath
  logic               do_refresh;
  logic               do_buzz;
  logic signed [10:0] fade_ext;
  logic signed [10:0] step_ext;
  logic signed [10:0] lvl_ext;
  logic signed [10:0] fade_next;
  logic               rising_next;
  logic [7:0]         yel_sat;
  logic [31:0]        elapsed;
  logic               pulse_due;
  logic               on_due;
  logic               off_due;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  // Warning fade: step toward the ceiling, then back toward zero.
  always_comb begin
    fade_ext = $signed({fade_q[9], fade_q});
    step_ext = $signed({3'b000, fade_step_q});
    lvl_ext  = $signed({3'b000, led_level_q});
    if (rising_q) begin
      fade_next   = fade_ext + step_ext;
      rising_next = !(fade_next >= lvl_ext);
    end else begin
      fade_next   = fade_ext - step_ext;
      rising_next = (fade_next <= 11'sd0);
    end
    if (fade_next < 11'sd0) begin
      yel_sat = 8'd0;
    end else if (fade_next > 11'sd255) begin
      yel_sat = 8'd255;
    end else begin
      yel_sat = fade_next[7:0];
    end
  end

  // Buzzer timing: modulo-2^32 elapsed time against each period.
  assign elapsed   = now_ms_i - last_q;
  assign pulse_due = elapsed >= {16'd0, pulse_period_q};
  assign on_due    = elapsed >= {16'd0, inter_on_q};
  assign off_due   = elapsed >= {16'd0, inter_off_q};

  // Next state for the request on the port.
  always_comb begin
    status_d   = status_q;
    mode_d     = mode_q;
    alarm_d    = alarm_q;
    last_d     = last_q;
    phase_d    = phase_q;
    fade_d     = fade_q;
    rising_d   = rising_q;
    pin_d      = pin_q;
    red_d      = red_q;
    yel_d      = yel_q;
    grn_d      = grn_q;
    do_refresh = 1'b0;
    do_buzz    = 1'b0;

    case (albpg_pkg::req_e'(req_type_i))
      albpg_pkg::REQ_TICK: begin
        do_refresh = 1'b1;
        do_buzz    = 1'b1;
      end
      albpg_pkg::REQ_STATUS: begin
        status_d   = albpg_pkg::status_e'(status_code_i);
        do_refresh = 1'b1;
        case (albpg_pkg::status_e'(status_code_i))
          albpg_pkg::ST_DANGER: begin
            mode_d  = albpg_pkg::PAT_CONTINUOUS;
            alarm_d = 1'b1;
          end
          albpg_pkg::ST_WARNING: begin
            mode_d  = albpg_pkg::PAT_PULSE;
            alarm_d = 1'b1;
          end
          default: begin
            mode_d  = albpg_pkg::PAT_OFF;
            alarm_d = 1'b0;
          end
        endcase
      end
      albpg_pkg::REQ_PATTERN: begin
        mode_d = albpg_pkg::pattern_e'(pattern_code_i);
      end
      default: begin
        // silence: blank everything, keep the status
        mode_d  = albpg_pkg::PAT_OFF;
        pin_d   = 1'b0;
        alarm_d = 1'b0;
        red_d   = 8'd0;
        yel_d   = 8'd0;
        grn_d   = 8'd0;
      end
    endcase

    // LED refresh against the status in force after this request
    if (do_refresh) begin
      case (status_d)
        albpg_pkg::ST_NORMAL: begin
          red_d = 8'd0;
          yel_d = 8'd0;
          grn_d = led_level_q;
        end
        albpg_pkg::ST_DANGER: begin
          red_d = led_level_q;
          yel_d = 8'd0;
          grn_d = 8'd0;
        end
        albpg_pkg::ST_WARNING: begin
          fade_d   = fade_next[9:0];
          rising_d = rising_next;
          red_d    = 8'd0;
          yel_d    = yel_sat;
          grn_d    = 8'd0;
        end
        default: begin
          red_d = 8'd0;
          yel_d = 8'd0;
          grn_d = 8'd0;
        end
      endcase
    end

    // Buzzer pattern, ticks only; a tick never changes the mode
    if (do_buzz) begin
      if (!buzzer_en_q) begin
        pin_d = 1'b0;
      end else begin
        case (mode_q)
          albpg_pkg::PAT_CONTINUOUS: begin
            pin_d = 1'b1;
          end
          albpg_pkg::PAT_PULSE: begin
            if (pulse_due) begin
              last_d  = now_ms_i;
              phase_d = !phase_q;
            end
            pin_d = pulse_due ? !phase_q : phase_q;
          end
          albpg_pkg::PAT_INTERMITTENT: begin
            if (!phase_q) begin
              pin_d = !on_due;
              if (on_due) begin
                last_d  = now_ms_i;
                phase_d = 1'b1;
              end
            end else begin
              pin_d = 1'b0;
              if (off_due) begin
                last_d  = now_ms_i;
                phase_d = 1'b0;
              end
            end
          end
          default: begin
            pin_d = 1'b0;
          end
        endcase
      end
    end

    res.red    = red_d;
    res.yellow = yel_d;
    res.green  = grn_d;
    res.buzzer = pin_d;
    res.alarm  = alarm_d;
    res.status = status_d;
  end

  // State and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_level_q    <= albpg_pkg::LED_LEVEL_RST;
      fade_step_q    <= albpg_pkg::FADE_STEP_RST;
      buzzer_en_q    <= 1'b1;
      pulse_period_q <= albpg_pkg::PULSE_PERIOD_RST;
      inter_on_q     <= albpg_pkg::INTER_ON_RST;
      inter_off_q    <= albpg_pkg::INTER_OFF_RST;
      status_q       <= albpg_pkg::ST_NORMAL;
      mode_q         <= albpg_pkg::PAT_OFF;
      alarm_q        <= 1'b0;
      last_q         <= '0;
      phase_q        <= 1'b0;
      fade_q         <= '0;
      rising_q       <= 1'b1;
      pin_q          <= 1'b0;
      red_q          <= '0;
      yel_q          <= '0;
      grn_q          <= '0;
    end else begin
      if (in_fire) begin
        status_q <= status_d;
        mode_q   <= mode_d;
        alarm_q  <= alarm_d;
        last_q   <= last_d;
        phase_q  <= phase_d;
        fade_q   <= fade_d;
        rising_q <= rising_d;
        pin_q    <= pin_d;
        red_q    <= red_d;
        yel_q    <= yel_d;
        grn_q    <= grn_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          albpg_pkg::CFG_LED_LEVEL:    led_level_q    <= cfg_wdata_i[7:0];
          albpg_pkg::CFG_FADE_STEP:    fade_step_q    <= cfg_wdata_i[7:0];
          albpg_pkg::CFG_BUZZER_ENABLE: begin
            buzzer_en_q <= cfg_wdata_i[0];
            // disabling the buzzer also drops the held level unless a request is accepted
            if (!cfg_wdata_i[0] && !in_fire) begin
              pin_q <= 1'b0;
            end
          end
          albpg_pkg::CFG_PULSE_PERIOD: pulse_period_q <= cfg_wdata_i;
          albpg_pkg::CFG_INTER_ON:     inter_on_q     <= cfg_wdata_i;
          albpg_pkg::CFG_INTER_OFF:    inter_off_q    <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // Output buffer: the skid entry fills only when the output entry is stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_ready_i) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_ready_i) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign red_level_o    = out_q.red;
  assign yellow_level_o = out_q.yellow;
  assign green_level_o  = out_q.green;
  assign buzzer_on_o    = out_q.buzzer;
  assign alarm_active_o = out_q.alarm;
  assign status_now_o   = out_q.status;

endmodule

@@ rtl/albpg_checker.sv @@
// ----------------------------------------------------------------------------
// Alarm LED / buzzer pattern generator port checker
// Watches the result channel for handshake and LED/status consistency.
// ----------------------------------------------------------------------------
`include "alarm_led_buzzer_pattern_gen_defines.svh"

module albpg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  red_level_o,
  input logic [7:0]  yellow_level_o,
  input logic [7:0]  green_level_o,
  input logic        buzzer_on_o,
  input logic        alarm_active_o,
  input logic [1:0]  status_now_o
);

  // A stalled result holds.
  `ALBPG_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable({red_level_o, yellow_level_o, green_level_o,
                            buzzer_on_o, alarm_active_o, status_now_o}),
    "result dropped or changed while stalled")

  // The alarm flag is only raised by a danger or warning status.
  `ALBPG_ASSERT_NOW(a_alarm_status, clk_i, rst_ni, out_valid_o && alarm_active_o,
    status_now_o == albpg_pkg::ST_DANGER || status_now_o == albpg_pkg::ST_WARNING,
    "alarm active without danger or warning status")

  // Yellow lights only in warning.
  `ALBPG_ASSERT_NOW(a_yellow_warn, clk_i, rst_ni,
    out_valid_o && status_now_o != albpg_pkg::ST_WARNING, yellow_level_o == 8'd0,
    "yellow lit outside warning")

  // Red lights only in danger.
  `ALBPG_ASSERT_NOW(a_red_danger, clk_i, rst_ni,
    out_valid_o && status_now_o != albpg_pkg::ST_DANGER, red_level_o == 8'd0,
    "red lit outside danger")

endmodule

bind alarm_led_buzzer_pattern_gen albpg_checker u_albpg_checker (.*);

@@ test/alarm_led_buzzer_pattern_gen_test.sv @@
// ----------------------------------------------------------------------------
// Alarm LED / buzzer pattern generator testbench
// Drives tick, status, pattern and silence requests with random idling on
// both channels, predicts every LED/buzzer indication and checks each one.
// ----------------------------------------------------------------------------
module alarm_led_buzzer_pattern_gen_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Indexes past the last register: writes there must change nothing
  localparam logic [albpg_pkg::CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [albpg_pkg::CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

  localparam int unsigned PHASE_COUNT = 6;
  localparam int unsigned PHASE_ITEMS = 260;

  // --------------------------------------------------------------------------
  // Indication predictor: own copy of the registers and the block state,
  // a queue of expected indications and the mismatch count.
  // --------------------------------------------------------------------------
  class indication_predictor;
    logic [albpg_pkg::LED_W-1:0]    led_level;
    logic [albpg_pkg::LED_W-1:0]    fade_step;
    logic                           buzzer_enable;
    logic [albpg_pkg::PERIOD_W-1:0] pulse_period;
    logic [albpg_pkg::PERIOD_W-1:0] on_time;
    logic [albpg_pkg::PERIOD_W-1:0] off_time;

    albpg_pkg::status_e                  cur_status;
    albpg_pkg::pattern_e                 buzzer_mode;
    logic                                alarm_flag;
    logic [albpg_pkg::TIME_W-1:0]        last_change_ms;
    logic                                pat_phase;
    logic signed [albpg_pkg::FADE_W-1:0] fade_value;
    logic                                fade_rising;
    logic                                buzzer_level;
    logic [albpg_pkg::LED_W-1:0]         duty_red;
    logic [albpg_pkg::LED_W-1:0]         duty_yellow;
    logic [albpg_pkg::LED_W-1:0]         duty_green;

    albpg_pkg::result_t expected_indications[$];
    int unsigned        mismatches;

    function new();
      led_level      = albpg_pkg::LED_LEVEL_RST;
      fade_step      = albpg_pkg::FADE_STEP_RST;
      buzzer_enable  = 1'b1;
      pulse_period   = albpg_pkg::PULSE_PERIOD_RST;
      on_time        = albpg_pkg::INTER_ON_RST;
      off_time       = albpg_pkg::INTER_OFF_RST;
      cur_status     = albpg_pkg::ST_NORMAL;
      buzzer_mode    = albpg_pkg::PAT_OFF;
      alarm_flag     = 1'b0;
      last_change_ms = '0;
      pat_phase      = 1'b0;
      fade_value     = '0;
      fade_rising    = 1'b1;
      buzzer_level   = 1'b0;
      duty_red       = '0;
      duty_yellow    = '0;
      duty_green     = '0;
      mismatches     = 0;
    endfunction

    function int unsigned pending();
      return expected_indications.size();
    endfunction

    function void write_reg(logic [albpg_pkg::CFG_IDX_W-1:0] idx,
                            logic [albpg_pkg::CFG_DAT_W-1:0] data);
      case (idx)
        albpg_pkg::CFG_LED_LEVEL:     led_level = data[albpg_pkg::LED_W-1:0];
        albpg_pkg::CFG_FADE_STEP:     fade_step = data[albpg_pkg::LED_W-1:0];
        albpg_pkg::CFG_BUZZER_ENABLE: begin
          buzzer_enable = data[0];
          if (!data[0]) buzzer_level = 1'b0;
        end
        albpg_pkg::CFG_PULSE_PERIOD:  pulse_period = data;
        albpg_pkg::CFG_INTER_ON:      on_time = data;
        albpg_pkg::CFG_INTER_OFF:     off_time = data;
        default: ;
      endcase
    endfunction

    function void refresh_duties();
      logic signed [albpg_pkg::FADE_W-1:0] step_s;
      logic signed [albpg_pkg::FADE_W-1:0] level_s;
      step_s  = $signed({2'b00, fade_step});
      level_s = $signed({2'b00, led_level});
      duty_red    = '0;
      duty_yellow = '0;
      duty_green  = '0;
      case (cur_status)
        albpg_pkg::ST_NORMAL: duty_green = led_level;
        albpg_pkg::ST_DANGER: duty_red = led_level;
        albpg_pkg::ST_WARNING: begin
          if (fade_rising) begin
            fade_value = fade_value + step_s;
            if (fade_value >= level_s) fade_rising = 1'b0;
          end else begin
            fade_value = fade_value - step_s;
            if (fade_value <= 0) fade_rising = 1'b1;
          end
          // saturate the yellow duty instead of truncating it
          if (fade_value < 0) duty_yellow = '0;
          else if (fade_value > 255) duty_yellow = 8'hFF;
          else duty_yellow = fade_value[albpg_pkg::LED_W-1:0];
        end
        default: ;
      endcase
    endfunction

    function void run_buzzer(logic [albpg_pkg::TIME_W-1:0] now);
      logic [albpg_pkg::TIME_W-1:0] elapsed;
      elapsed = now - last_change_ms;
      if (!buzzer_enable || buzzer_mode == albpg_pkg::PAT_OFF) begin
        buzzer_level = 1'b0;
      end else begin
        case (buzzer_mode)
          albpg_pkg::PAT_CONTINUOUS: buzzer_level = 1'b1;
          albpg_pkg::PAT_PULSE: begin
            if (elapsed >= {16'h0, pulse_period}) begin
              last_change_ms = now;
              pat_phase      = ~pat_phase;
            end
            buzzer_level = pat_phase;
          end
          default: begin
            if (!pat_phase) begin
              buzzer_level = 1'b1;
              if (elapsed >= {16'h0, on_time}) begin
                last_change_ms = now;
                pat_phase      = 1'b1;
                buzzer_level   = 1'b0;
              end
            end else begin
              // the level stays low on the tick that ends the off time
              buzzer_level = 1'b0;
              if (elapsed >= {16'h0, off_time}) begin
                last_change_ms = now;
                pat_phase      = 1'b0;
              end
            end
          end
        endcase
      end
    endfunction

    function void note_request(albpg_pkg::req_e req, logic [albpg_pkg::TIME_W-1:0] now,
                               albpg_pkg::status_e st, albpg_pkg::pattern_e pat);
      albpg_pkg::result_t exp_ind;
      case (req)
        albpg_pkg::REQ_TICK: begin
          refresh_duties();
          run_buzzer(now);
        end
        albpg_pkg::REQ_STATUS: begin
          cur_status = st;
          case (st)
            albpg_pkg::ST_DANGER: begin
              buzzer_mode = albpg_pkg::PAT_CONTINUOUS;
              alarm_flag  = 1'b1;
            end
            albpg_pkg::ST_WARNING: begin
              buzzer_mode = albpg_pkg::PAT_PULSE;
              alarm_flag  = 1'b1;
            end
            default: begin
              buzzer_mode = albpg_pkg::PAT_OFF;
              alarm_flag  = 1'b0;
            end
          endcase
          refresh_duties();
        end
        albpg_pkg::REQ_PATTERN: buzzer_mode = pat;
        default: begin
          buzzer_mode  = albpg_pkg::PAT_OFF;
          buzzer_level = 1'b0;
          duty_red     = '0;
          duty_yellow  = '0;
          duty_green   = '0;
          alarm_flag   = 1'b0;
        end
      endcase
      exp_ind.red    = duty_red;
      exp_ind.yellow = duty_yellow;
      exp_ind.green  = duty_green;
      exp_ind.buzzer = buzzer_level;
      exp_ind.alarm  = alarm_flag;
      exp_ind.status = cur_status;
      expected_indications.push_back(exp_ind);
    endfunction

    function void check_indication(albpg_pkg::result_t got);
      albpg_pkg::result_t exp_ind;
      if (expected_indications.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] indication with no request pending: ", $realtime,
                   "r=%0d y=%0d g=%0d bz=%0b al=%0b st=%0d",
                   got.red, got.yellow, got.green, got.buzzer, got.alarm, got.status);
        return;
      end
      exp_ind = expected_indications.pop_front();
      if (got.red !== exp_ind.red || got.yellow !== exp_ind.yellow ||
          got.green !== exp_ind.green || got.buzzer !== exp_ind.buzzer ||
          got.alarm !== exp_ind.alarm || got.status !== exp_ind.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] indication wrong: ", $realtime,
                   "exp r=%0d y=%0d g=%0d bz=%0b al=%0b st=%0d, ",
                   exp_ind.red, exp_ind.yellow, exp_ind.green, exp_ind.buzzer,
                   exp_ind.alarm, exp_ind.status,
                   "got r=%0d y=%0d g=%0d bz=%0b al=%0b st=%0d",
                   got.red, got.yellow, got.green, got.buzzer, got.alarm, got.status);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block ports; every input holds a known value from time zero
  // --------------------------------------------------------------------------
  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [1:0]  req_type_i     = albpg_pkg::REQ_TICK;
  logic [31:0] now_ms_i       = '0;
  logic [1:0]  status_code_i  = albpg_pkg::ST_NORMAL;
  logic [1:0]  pattern_code_i = albpg_pkg::PAT_OFF;
  logic        cfg_we_i       = 1'b0;
  logic [2:0]  cfg_idx_i      = albpg_pkg::CFG_LED_LEVEL;
  logic [15:0] cfg_wdata_i    = '0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b1;
  logic [7:0]  red_level_o;
  logic [7:0]  yellow_level_o;
  logic [7:0]  green_level_o;
  logic        buzzer_on_o;
  logic        alarm_active_o;
  logic [1:0]  status_now_o;

  indication_predictor predictor = new();

  // Idling switches; both drop for the last phase of the run
  bit                           send_idle_on  = 1'b1;
  bit                           ready_idle_on = 1'b1;
  logic [albpg_pkg::TIME_W-1:0] clock_ms;
  int unsigned                  time_scale;

  alarm_led_buzzer_pattern_gen i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .now_ms_i       (now_ms_i),
    .status_code_i  (status_code_i),
    .pattern_code_i (pattern_code_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .red_level_o    (red_level_o),
    .yellow_level_o (yellow_level_o),
    .green_level_o  (green_level_o),
    .buzzer_on_o    (buzzer_on_o),
    .alarm_active_o (alarm_active_o),
    .status_now_o   (status_now_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Hard stop in case the handshakes hang
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic albpg_pkg::status_e rand_status();
    return albpg_pkg::status_e'(2'($urandom_range(0, 3)));
  endfunction

  function automatic albpg_pkg::pattern_e rand_pattern();
    return albpg_pkg::pattern_e'(2'($urandom_range(0, 3)));
  endfunction

  // Present one request, hold it until accepted, then predict its indication.
  // Call only right after a rising edge.
  task automatic send_request(albpg_pkg::req_e req, logic [albpg_pkg::TIME_W-1:0] now,
                              albpg_pkg::status_e st, albpg_pkg::pattern_e pat);
    int unsigned gap;
    gap = 0;
    if (send_idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 15);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= req;
    now_ms_i       <= now;
    status_code_i  <= st;
    pattern_code_i <= pat;
    do @(posedge clk_i); while (!in_ready_o);
    predictor.note_request(req, now, st, pat);
  endtask

  // Unused fields of each request carry random values
  task automatic tick(logic [albpg_pkg::TIME_W-1:0] now);
    send_request(albpg_pkg::REQ_TICK, now, rand_status(), rand_pattern());
  endtask

  task automatic status_update(albpg_pkg::status_e st);
    send_request(albpg_pkg::REQ_STATUS, $urandom(), st, rand_pattern());
  endtask

  task automatic set_pattern(albpg_pkg::pattern_e pat);
    send_request(albpg_pkg::REQ_PATTERN, $urandom(), rand_status(), pat);
  endtask

  task automatic silence();
    send_request(albpg_pkg::REQ_SILENCE, $urandom(), rand_status(), rand_pattern());
  endtask

  // Drop valid and hold off until every indication has come back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (predictor.pending() != 0);
  endtask

  // Hold the write enable high while a register is written; the caller drops it
  task automatic write_reg(logic [albpg_pkg::CFG_IDX_W-1:0] idx,
                           logic [albpg_pkg::CFG_DAT_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    predictor.write_reg(idx, data);
  endtask

  // Sample the result channel before this edge's updates land
  always @(posedge clk_i) begin : watch_indications
    albpg_pkg::result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.red    = red_level_o;
      got.yellow = yellow_level_o;
      got.green  = green_level_o;
      got.buzzer = buzzer_on_o;
      got.alarm  = alarm_active_o;
      got.status = status_now_o;
      predictor.check_indication(got);
    end
  end

  // Receiver: random stall bursts between stretches of ready
  initial begin
    @(posedge clk_i);
    forever begin
      if (ready_idle_on && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  initial begin
    logic [albpg_pkg::LED_W-1:0]    lvl;
    logic [albpg_pkg::LED_W-1:0]    stp;
    logic                           en;
    logic [albpg_pkg::PERIOD_W-1:0] pp;
    logic [albpg_pkg::PERIOD_W-1:0] on_ms;
    logic [albpg_pkg::PERIOD_W-1:0] off_ms;
    logic [15:0]                    junk;
    int unsigned                    pick;

    // Hold reset low, then release it at an edge
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- Directed part with reset register values ----
    tick(32'h0);                          // normal lights green at full level
    status_update(albpg_pkg::ST_DANGER);  // red, alarm set, buzzer not yet re-evaluated
    tick(32'd10);                         // continuous drives the buzzer high
    status_update(albpg_pkg::ST_WARNING); // fade starts, pulse pattern selected
    tick(32'd500);                        // pulse period not yet elapsed
    tick(32'd1000);                       // elapsed equals the period: toggle
    set_pattern(albpg_pkg::PAT_INTERMITTENT);
    tick(32'd1100);                       // off time running
    tick(32'd1800);                       // off time ends, level stays low
    tick(32'd1900);                       // on time running
    tick(32'd2000);                       // on time ends
    set_pattern(albpg_pkg::PAT_OFF);
    tick(32'd2100);
    set_pattern(albpg_pkg::PAT_CONTINUOUS);
    tick(32'hFFFF_FFFF);
    silence();                            // blank everything, keep the status
    tick(32'h0);                          // wrapped timestamp, warning relights
    status_update(albpg_pkg::ST_UNKNOWN);
    status_update(albpg_pkg::ST_NORMAL);
    status_update(albpg_pkg::ST_DANGER);
    tick(32'd5000);                       // buzzer high before it is disabled

    // Disable the buzzer while it is high: the held level must drop at once
    wait_idle();
    write_reg(albpg_pkg::CFG_BUZZER_ENABLE, 16'h0000);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    set_pattern(albpg_pkg::PAT_CONTINUOUS);
    tick(32'd5001);

    // Zero periods advance patterns on every tick; a zero step freezes the fade
    wait_idle();
    write_reg(albpg_pkg::CFG_BUZZER_ENABLE, 16'h0001);
    write_reg(albpg_pkg::CFG_PULSE_PERIOD, 16'h0000);
    write_reg(albpg_pkg::CFG_INTER_ON, 16'h0000);
    write_reg(albpg_pkg::CFG_INTER_OFF, 16'h0000);
    write_reg(albpg_pkg::CFG_FADE_STEP, 16'h0000);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    status_update(albpg_pkg::ST_WARNING);
    tick(32'd7);
    tick(32'd7);
    set_pattern(albpg_pkg::PAT_INTERMITTENT);
    tick(32'd7);
    tick(32'd7);

    // ---- Random phases, each under its own register setting ----
    for (int unsigned ph = 0; ph < PHASE_COUNT; ph++) begin
      wait_idle();
      case (ph)
        0: begin  // finest fade, tiny periods: patterns change constantly
          lvl = 8'd255; stp = 8'd1; en = 1'b1;
          pp = 16'd3; on_ms = 16'd2; off_ms = 16'd5;
        end
        1: begin  // dark LEDs, coarsest step, longest periods
          lvl = 8'd0; stp = 8'd255; en = 1'b1;
          pp = 16'hFFFF; on_ms = 16'hFFFF; off_ms = 16'hFFFF;
        end
        2: begin  // steps that overshoot the ceiling, buzzer disabled
          lvl = 8'($urandom_range(200, 255)); stp = 8'($urandom_range(128, 255));
          en = 1'b0;
          pp = 16'($urandom_range(1, 50)); on_ms = 16'($urandom_range(1, 50));
          off_ms = 16'($urandom_range(1, 50));
        end
        3: begin  // zero step and zero periods
          lvl = 8'($urandom_range(0, 255)); stp = 8'd0; en = 1'b1;
          pp = 16'd0; on_ms = 16'd0; off_ms = 16'd0;
        end
        4: begin  // anything goes
          lvl = 8'($urandom_range(0, 255)); stp = 8'($urandom_range(0, 255));
          en = 1'($urandom_range(0, 1));
          pp = 16'($urandom()); on_ms = 16'($urandom()); off_ms = 16'($urandom());
        end
        default: begin  // reset values, no idling on either side
          lvl = albpg_pkg::LED_LEVEL_RST; stp = albpg_pkg::FADE_STEP_RST; en = 1'b1;
          pp = albpg_pkg::PULSE_PERIOD_RST; on_ms = albpg_pkg::INTER_ON_RST;
          off_ms = albpg_pkg::INTER_OFF_RST;
          send_idle_on  = 1'b0;
          ready_idle_on = 1'b0;
        end
      endcase

      // Upper bits of the narrow registers carry junk that must be dropped
      junk = 16'($urandom());
      write_reg(albpg_pkg::CFG_LED_LEVEL, {junk[15:8], lvl});
      write_reg(albpg_pkg::CFG_FADE_STEP, {junk[7:0], stp});
      junk = 16'($urandom());
      write_reg(albpg_pkg::CFG_BUZZER_ENABLE, {junk[15:1], en});
      write_reg(albpg_pkg::CFG_PULSE_PERIOD, pp);
      write_reg(albpg_pkg::CFG_INTER_ON, on_ms);
      write_reg(albpg_pkg::CFG_INTER_OFF, off_ms);
      if (ph == 4) begin
        write_reg(CFG_SPARE_6, 16'($urandom()));
        write_reg(CFG_SPARE_7, 16'($urandom()));
      end
      cfg_we_i <= 1'b0;
      @(posedge clk_i);

      // Advance time in steps comparable to the longest period
      time_scale = {16'd0, pp};
      if (on_ms > time_scale) time_scale = {16'd0, on_ms};
      if (off_ms > time_scale) time_scale = {16'd0, off_ms};
      time_scale = time_scale / 2 + 1;
      clock_ms = $urandom();

      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          // mostly monotonic time, now and then a jump anywhere
          if ($urandom_range(0, 9) == 0) clock_ms = $urandom();
          else clock_ms = clock_ms + $urandom_range(0, time_scale);
          tick(clock_ms);
        end else if (pick < 80) begin
          status_update(rand_status());
        end else if (pick < 92) begin
          set_pattern(rand_pattern());
        end else begin
          silence();
        end
        // Occasionally hold off the sender until the block has drained
        if ($urandom_range(0, 149) == 0) wait_idle();
      end
    end

    // Drain, then check that nothing is left pending
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (predictor.pending() != 0) begin
      $display("%0d requests left without an indication", predictor.pending());
      predictor.mismatches += predictor.pending();
    end
    if (predictor.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
